>>> hw/rtl/nbs_pkg.sv
// shared constants and types for the n-gram bloom signature block
// no dependencies; imported by every module of the block

package nbs_pkg;

   // bytes per n-gram window and signature width in bits
   localparam int WINDOW    = 4;
   localparam int SIG_BITS  = 256;

   // derived sizes
   localparam int HIST       = WINDOW - 1;
   localparam int WIN_SLOTS  = (HIST > 0) ? HIST : 1;
   localparam int POS_W      = $clog2(SIG_BITS);
   localparam int SIG_WORDS  = SIG_BITS / 64;
   localparam int WORD_SEL_W = (SIG_WORDS > 1) ? $clog2(SIG_WORDS) : 1;
   localparam int FILL_W     = 3;
   localparam int WORD_NUM_W = 2;

   // decoupling queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // one classified byte on its way to the bitmap
   typedef struct packed {
      logic             hit;   // full window present, set bit at pos
      logic [POS_W-1:0] pos;   // window sum modulo SIG_BITS
      logic             eob;   // last byte of the buffer
   } nbs_entry_type;

   // queue read side as seen by the back end
   typedef struct packed {
      logic          valid;
      nbs_entry_type entry;
   } nbs_queue_out_type;

endpackage

>>> hw/rtl/nbs_front.sv
// front end: accepts bytes, keeps the byte window and fill count, forms bit positions
// depends on nbs_pkg

module nbs_front
   import nbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [7:0]    req_data_byte,
   input  logic          req_end_of_buffer,
   input  logic          push_ready,
   output logic          push_valid,
   output nbs_entry_type push_entry
);

   logic [7:0]        window_ff [WIN_SLOTS];
   logic [7:0]        window_in [WIN_SLOTS];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [7:0]        sum;
   logic              take;

   assign take       = req_valid && push_ready;
   assign push_valid = req_valid;

   // window sum over held bytes plus the new one
   always_comb begin
      sum = req_data_byte;
      for (int i = 0; i < HIST; i++) begin
         sum = sum + window_ff[i];
      end
   end

   assign push_entry.hit = (fill_ff >= FILL_W'(HIST));
   assign push_entry.pos = sum[POS_W-1:0];
   assign push_entry.eob = req_end_of_buffer;

   // shift the new byte in, oldest at index 0; clear at end of buffer
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (take) begin
         if (req_end_of_buffer) begin
            for (int i = 0; i < WIN_SLOTS; i++) begin
               window_in[i] = 8'd0;
            end
            fill_in = '0;
         end else begin
            for (int i = 0; i + 1 < HIST; i++) begin
               window_in[i] = window_ff[i + 1];
            end
            if (HIST > 0) begin
               window_in[WIN_SLOTS - 1] = req_data_byte;
            end
            if (fill_ff < FILL_W'(HIST)) begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < WIN_SLOTS; i++) begin
            window_ff[i] <= 8'd0;
         end
      end else begin
         fill_ff   <= fill_in;
         window_ff <= window_in;
      end
   end

endmodule

>>> hw/rtl/nbs_queue.sv
// short register queue that decouples the front end from the back end
// depends on nbs_pkg

module nbs_queue
   import nbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  nbs_entry_type     push_entry,
   output logic              push_ready,
   input  logic              pop,
   output nbs_queue_out_type head
);

   nbs_entry_type        entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff;
   logic [Q_CNT_W-1:0]   count_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (count_ff < Q_CNT_W'(Q_DEPTH));
   assign do_push    = push_valid && push_ready;
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/nbs_back.sv
// back end: sets bitmap bits, snapshots the bitmap at end of buffer and sends its words
// depends on nbs_pkg

module nbs_back
   import nbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  nbs_queue_out_type     head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_sig_word,
   output logic [WORD_NUM_W-1:0] rsp_word_number,
   output logic                  rsp_last_word
);

   logic [SIG_BITS-1:0]      bitmap_ff;
   logic [SIG_BITS-1:0]      bitmap_in;
   logic [SIG_WORDS-1:0][63:0] snap_ff;
   logic [SIG_WORDS-1:0][63:0] snap_in;
   logic                     busy_ff;
   logic                     busy_in;
   logic [WORD_SEL_W-1:0]    word_ff;
   logic [WORD_SEL_W-1:0]    word_in;
   logic [SIG_BITS-1:0]      merged;
   logic                     last;
   logic                     sent;
   logic                     can_load;

   assign last      = (word_ff == WORD_SEL_W'(SIG_WORDS - 1));
   assign sent      = busy_ff && !rsp_stall;
   assign can_load  = !busy_ff || (sent && last);
   assign pop       = head.valid && (!head.entry.eob || can_load);

   assign rsp_valid       = busy_ff;
   assign rsp_sig_word    = snap_ff[word_ff];
   assign rsp_word_number = WORD_NUM_W'(word_ff);
   assign rsp_last_word   = last;

   // bitmap with the head byte's bit applied
   assign merged = head.entry.hit ? (bitmap_ff | (SIG_BITS'(1) << head.entry.pos))
                                  : bitmap_ff;

   // absorb a byte, step the word counter, load a new snapshot at end of buffer
   always_comb begin
      bitmap_in = bitmap_ff;
      snap_in   = snap_ff;
      busy_in   = busy_ff;
      word_in   = word_ff;
      if (sent) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            word_in = word_ff + WORD_SEL_W'(1);
         end
      end
      if (pop) begin
         if (head.entry.eob) begin
            snap_in   = merged;
            bitmap_in = '0;
            busy_in   = 1'b1;
            word_in   = '0;
         end else begin
            bitmap_in = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff <= '0;
         busy_ff   <= 1'b0;
         word_ff   <= '0;
      end else begin
         bitmap_ff <= bitmap_in;
         busy_ff   <= busy_in;
         word_ff   <= word_in;
      end
   end

   // snapshot payload, no reset needed
   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

endmodule

>>> hw/rtl/ngram_bloom_signature.sv
// top level of the n-gram bloom signature block
// depends on nbs_pkg, nbs_front, nbs_queue and nbs_back
//
// usage:
//   req channel: one buffer byte per transfer (req_data_byte), with
//   req_end_of_buffer high on the buffer's last byte. a transfer happens at
//   a clock edge with req_valid high and req_stall low.
//   rsp channel: after the last byte, SIG_BITS/64 transfers of 64 signature
//   bits each, lowest word first, rsp_word_number counting up and
//   rsp_last_word high on the final word.
// response: the end of buffer byte is registered in the queue, then the back
//   end loads the signature snapshot and raises rsp_valid with the first word;
//   the remaining words follow one per cycle while rsp_stall is low.
// throughput: one byte per cycle while req_stall is low, set by the window
//   sum in the front end and the single bitmap update in the back end. an end
//   of buffer byte waits in the two-entry queue while the previous signature
//   is still being sent, so buffers shorter than SIG_BITS/64 bytes run slower.
// stall: rsp_stall holds the current word; bytes keep going into the bitmap
//   until the queue fills with a waiting end of buffer, then req_stall rises.
// reset: synchronous, active high; clears window, fill count, bitmap and
//   queue, no response is pending afterwards.

module ngram_bloom_signature
   import nbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_buffer,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_sig_word,
   output logic [WORD_NUM_W-1:0] rsp_word_number,
   output logic                  rsp_last_word
);

   logic              push_valid;
   logic              push_ready;
   nbs_entry_type     push_entry;
   nbs_queue_out_type head;
   logic              pop;

   assign req_stall = !push_ready;

   // classify incoming bytes
   nbs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .push_ready        (push_ready),
      .push_valid        (push_valid),
      .push_entry        (push_entry)
   );

   // decoupling queue
   nbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head)
   );

   // bitmap and signature output
   nbs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sig_word    (rsp_sig_word),
      .rsp_word_number (rsp_word_number),
      .rsp_last_word   (rsp_last_word)
   );

`ifndef SYNTHESIS
   // nothing is pending right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a sent non-final word is followed at once by the next word of the same signature
   a_word_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word) |=>
      (rsp_valid && rsp_word_number == $past(rsp_word_number) + WORD_NUM_W'(1)))
      else $error("signature words not sent back to back");

   // the final word carries the highest word number
   a_last_number: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_word) |-> (rsp_word_number == WORD_NUM_W'(SIG_WORDS - 1)))
      else $error("last word flag on wrong word");
`endif

endmodule

>>> tb/ngram_bloom_signature_tb.sv
// self-checking testbench for ngram_bloom_signature: directed table, then random buffers
// predicts each signature word from its own window and bitmap model
// depends on nbs_pkg and the ngram_bloom_signature rtl

module ngram_bloom_signature_tb;
   import nbs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_GAP      = 20;
   localparam int PHASE_ITEMS  = 24;

   // bitmaps for the literal rows of the table
   localparam logic [SIG_BITS-1:0] MAP_EMPTY = '0;
   localparam logic [SIG_BITS-1:0] MAP_BIT0  = SIG_BITS'(1);
   localparam logic [SIG_BITS-1:0] MAP_FF    = MAP_BIT0 << ((4 * 255) % SIG_BITS);

   // one expected signature word
   typedef struct packed {
      logic [63:0]           word;
      logic [WORD_NUM_W-1:0] num;
      logic                  last;
   } sig_word_type;

   // one row of the directed table
   typedef struct packed {
      logic [7:0]          data;
      logic                eob;
      logic                lit;
      logic [SIG_BITS-1:0] lit_map;
   } byte_row_type;

   localparam int N_ROWS = 24;
   localparam byte_row_type BYTE_ROWS [N_ROWS] = '{
      // single byte after reset: too short, empty signature
      '{8'h00, 1'b1, 1'b1, MAP_EMPTY},
      // one byte short of a full window
      '{8'hFF, 1'b0, 1'b0, MAP_EMPTY},
      '{8'hFF, 1'b0, 1'b0, MAP_EMPTY},
      '{8'hFF, 1'b1, 1'b1, MAP_EMPTY},
      // all-zero window sets bit zero
      '{8'h00, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h00, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h00, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h00, 1'b1, 1'b1, MAP_BIT0},
      // all-ones window, sum wraps
      '{8'hFF, 1'b0, 1'b0, MAP_EMPTY},
      '{8'hFF, 1'b0, 1'b0, MAP_EMPTY},
      '{8'hFF, 1'b0, 1'b0, MAP_EMPTY},
      '{8'hFF, 1'b1, 1'b1, MAP_FF},
      // bytes with the top bit set are summed unsigned
      '{8'h80, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h80, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h80, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h80, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h7F, 1'b1, 1'b0, MAP_EMPTY},
      // mixed buffer, several windows
      '{8'h01, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h02, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h55, 1'b0, 1'b0, MAP_EMPTY},
      '{8'hAA, 1'b0, 1'b0, MAP_EMPTY},
      '{8'h0F, 1'b0, 1'b0, MAP_EMPTY},
      '{8'hF0, 1'b1, 1'b0, MAP_EMPTY},
      // no end mark: carries into the first random buffer
      '{8'h3C, 1'b0, 1'b0, MAP_EMPTY}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  req_end_of_buffer = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [63:0]           rsp_sig_word;
   logic [WORD_NUM_W-1:0] rsp_word_number;
   logic                  rsp_last_word;

   // signature model state
   logic [7:0]          hist_bytes [WIN_SLOTS];
   int                  fill_cnt;
   logic [SIG_BITS-1:0] sig_map;
   sig_word_type        sig_words_due [$];

   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int send_calm = 0;
   int rsp_calm = 0;

   ngram_bloom_signature DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sig_word      (rsp_sig_word),
      .rsp_word_number   (rsp_word_number),
      .rsp_last_word     (rsp_last_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stall, with calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm <= rsp_calm - 1;
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(63) == 0) rsp_calm <= 24;
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // compare each rsp transfer with the oldest expected word
   always @(posedge clock) begin
      sig_word_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sig_words_due.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual %h num %0d last %0b",
                     $time, rsp_sig_word, rsp_word_number, rsp_last_word);
            errors++;
         end else begin
            due = sig_words_due.pop_front();
            if (rsp_sig_word !== due.word) begin
               $display("%0t: sig_word mismatch: expected %h, actual %h",
                        $time, due.word, rsp_sig_word);
               errors++;
            end
            if (rsp_word_number !== due.num) begin
               $display("%0t: word_number mismatch: expected %0d, actual %0d",
                        $time, due.num, rsp_word_number);
               errors++;
            end
            if (rsp_last_word !== due.last) begin
               $display("%0t: last_word mismatch: expected %0b, actual %0b",
                        $time, due.last, rsp_last_word);
               errors++;
            end
         end
      end
   end

   // clear window, fill count and bitmap
   task automatic clear_signature();
      for (int i = 0; i < WIN_SLOTS; i++) hist_bytes[i] = 8'h00;
      fill_cnt = 0;
      sig_map  = '0;
   endtask

   // fold one accepted byte into the bitmap, queue the words on end of buffer
   task automatic absorb_byte(input logic [7:0] b, input logic eob, input logic lit,
                              input logic [SIG_BITS-1:0] lit_map);
      logic [31:0]         sum;
      logic [SIG_BITS-1:0] out_map;
      sig_word_type        w;
      if (fill_cnt >= HIST) begin
         sum = {24'h0, b};
         for (int i = 0; i < HIST; i++) sum += {24'h0, hist_bytes[i]};
         sig_map[sum[POS_W-1:0]] = 1'b1;
      end
      // newest byte at the top, oldest at index zero
      if (HIST > 0) begin
         for (int i = 0; i + 1 < HIST; i++) hist_bytes[i] = hist_bytes[i + 1];
         hist_bytes[WIN_SLOTS-1] = b;
      end
      if (fill_cnt < HIST) fill_cnt++;
      if (eob) begin
         out_map = lit ? lit_map : sig_map;
         for (int k = 0; k < SIG_WORDS; k++) begin
            w.word = out_map[k*64 +: 64];
            w.num  = k[WORD_NUM_W-1:0];
            w.last = (k == SIG_WORDS - 1);
            sig_words_due.push_back(w);
         end
         clear_signature();
      end
   endtask

   // one req transfer, after a random idle gap
   task automatic send_item(input logic [7:0] d, input logic eob, input logic lit,
                            input logic [SIG_BITS-1:0] lit_map);
      int gap;
      gap = 0;
      if (send_calm > 0) begin
         send_calm--;
      end else begin
         if ($urandom_range(7) == 0) send_calm = 10;
         while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'($urandom);
         req_end_of_buffer <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_end_of_buffer <= eob;
      do @(posedge clock); while (req_stall);
      absorb_byte(d, eob, lit, lit_map);
   endtask

   // hold the sender until every expected word has come
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sig_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random buffers, mostly short, some long, some with extreme bytes
   task automatic run_phase(input int s_pct, input int r_pct, input int n_items);
      int         sent;
      int         len;
      int         extreme;
      logic [7:0] b;
      send_idle_pct = s_pct;
      rsp_stall_pct = r_pct;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(11, 1);
         extreme = ($urandom_range(4) == 0);
         for (int k = 0; k < len; k++) begin
            b = 8'($urandom);
            if (extreme) begin
               case ($urandom_range(3))
                  0: b = 8'h00;
                  1: b = 8'hFF;
                  2: b = 8'h80;
                  default: b = 8'h7F;
               endcase
            end
            send_item(b, k == len - 1, 1'b0, MAP_EMPTY);
         end
         sent += len;
         if ($urandom_range(11) == 0) drain_results();
      end
      drain_results();
   endtask

   initial begin
      clear_signature();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling
      for (int r = 0; r < N_ROWS; r++)
         send_item(BYTE_ROWS[r].data, BYTE_ROWS[r].eob, BYTE_ROWS[r].lit,
                   BYTE_ROWS[r].lit_map);
      drain_results();

      // random phases: none, sender idle, receiver stall, both
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(52, 0, PHASE_ITEMS);
      run_phase(0, 52, PHASE_ITEMS);
      run_phase(24, 24, PHASE_ITEMS);

      if (errors == 0 && sig_words_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
